@@ src/stereo_biquad_lowpass_mix_unit_macros.svh @@
// Assertion macros for the stereo biquad low-pass mix unit.
// Used by the top level; needs no other file.
`ifndef STEREO_BIQUAD_LOWPASS_MIX_UNIT_MACROS_SVH
`define STEREO_BIQUAD_LOWPASS_MIX_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define SBLM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sblm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SBLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sblm: next-cycle check failed");

`else

`define SBLM_ASSERT_IMP(label, clk, rst, ante, cons)
`define SBLM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/sblm_pkg.sv @@
// Shared types, codes and constants of the stereo biquad low-pass mix unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sblm_pkg;

  localparam int COEF_BITS          = 32;
  localparam int MIX_BITS           = 17;
  localparam int MIX_FRAC_BITS      = 16;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 28;
  localparam int DEF_STATE_BITS     = 40;

  localparam logic [MIX_BITS-1:0] MIX_ONE = 17'h10000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4,
    REG_WET_MIX = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_DONE
  } core_state_t;

  // Products of one channel, in the order they are formed.
  typedef enum logic [2:0] {
    OP_B0,
    OP_B1,
    OP_A1,
    OP_B2,
    OP_A2,
    OP_MIX
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

  function automatic op_t next_op(input op_t op);
    op_t result;
    unique case (op)
      OP_B0:   result = OP_B1;
      OP_B1:   result = OP_A1;
      OP_A1:   result = OP_B2;
      OP_B2:   result = OP_A2;
      OP_A2:   result = OP_MIX;
      default: result = OP_B0;
    endcase
    return result;
  endfunction

endpackage

`default_nettype wire

@@ src/sblm_serial_mult.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// Depends on sblm_pkg.
`default_nettype none

module sblm_serial_mult import sblm_pkg::*; #(
  parameter int A_BITS = COEF_BITS,
  parameter int B_BITS = DEF_SAMPLE_BITS + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [A_BITS-1:0]         a,
  input  logic signed [B_BITS-1:0]         b,
  output mul_stat_t                        stat,
  output logic signed [A_BITS+B_BITS-1:0]  prod
);

  localparam int P_BITS   = A_BITS + B_BITS;
  localparam int CNT_BITS = $clog2(B_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(B_BITS - 1);

  logic signed [P_BITS-1:0] acc;
  logic signed [P_BITS-1:0] mcand;
  logic        [B_BITS-1:0] mplier;
  logic      [CNT_BITS-1:0] cnt;
  logic                     busy;
  logic                     done;
  logic signed [P_BITS-1:0] addend;
  logic signed [P_BITS-1:0] sum;

  // The multiplier's top bit has negative weight, so its partial product is subtracted.
  assign addend = mplier[0] ? mcand : '0;
  assign sum    = (cnt == LAST) ? (acc - addend) : (acc + addend);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= {{B_BITS{a[A_BITS-1]}}, a};
      mplier <= b;
      cnt    <= '0;
    end else if (busy) begin
      acc    <= sum;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = acc;

endmodule

`default_nettype wire

@@ src/sblm_core.sv @@
// Sequencer and datapath of both filter sections: delay words, rounding,
// saturation and the dry/wet blend. Depends on sblm_pkg and sblm_serial_mult.
`default_nettype none

module sblm_core import sblm_pkg::*; #(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int STATE_BITS     = DEF_STATE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic signed [COEF_BITS-1:0]   coef_b0,
  input  logic signed [COEF_BITS-1:0]   coef_b1,
  input  logic signed [COEF_BITS-1:0]   coef_b2,
  input  logic signed [COEF_BITS-1:0]   coef_a1,
  input  logic signed [COEF_BITS-1:0]   coef_a2,
  input  logic        [MIX_BITS-1:0]    wet_mix,
  input  logic                          res_take,
  output core_stat_t                    stat,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out
);

  localparam int B_BITS = SAMPLE_BITS + 1;
  localparam int PW     = COEF_BITS + B_BITS;
  localparam int WMAX   = (PW > STATE_BITS) ? PW : STATE_BITS;
  localparam int W      = WMAX + 2;

  localparam logic signed [W-1:0] HALF_F =
    {{(W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [W-1:0] HALF_M =
    {{(W-1){1'b0}}, 1'b1} << (MIX_FRAC_BITS - 1);
  localparam logic signed [W-1:0] S_MAX =
    {{(W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN =
    {{(W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [W-1:0] ST_MAX =
    {{(W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] ST_MIN =
    {{(W-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};

  core_state_t state, state_next;
  op_t         op, op_next;
  logic        ch, ch_next;
  logic        mul_start;

  logic signed [SAMPLE_BITS-1:0] x_l;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] wet;
  logic signed [W-1:0]           acc;
  logic signed [STATE_BITS-1:0]  d1 [2];
  logic signed [STATE_BITS-1:0]  d2 [2];

  logic        [MIX_BITS-1:0]    mix_c;
  logic signed [SAMPLE_BITS-1:0] x_sel;
  logic signed [B_BITS-1:0]      bx;
  logic signed [B_BITS-1:0]      bw;
  logic signed [B_BITS-1:0]      bd;
  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [B_BITS-1:0]      mul_b;
  mul_stat_t                     mstat;
  logic signed [PW-1:0]          prod;

  logic signed [W-1:0] p_ext;
  logic signed [W-1:0] rnd;
  logic signed [W-1:0] x_e;
  logic signed [W-1:0] d1e;
  logic signed [W-1:0] d2e;
  logic signed [W-1:0] wet_sum;
  logic signed [W-1:0] wet_sat;
  logic signed [W-1:0] tap1;
  logic signed [W-1:0] dnew;
  logic signed [W-1:0] dnew_sat;
  logic signed [W-1:0] mix_sum;
  logic signed [W-1:0] mix_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_B0;
      ch    <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    ch_next        = ch;
    mul_start      = 1'b0;
    stat.busy      = 1'b1;
    stat.res_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        stat.busy = 1'b0;
        if (start && !cmd) begin
          state_next = ST_LOAD;
          op_next    = OP_B0;
          ch_next    = 1'b0;
        end
      end
      ST_LOAD: begin
        mul_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mstat.done) begin
          if (op == OP_MIX) begin
            if (ch) begin
              state_next = ST_DONE;
            end else begin
              ch_next    = 1'b1;
              op_next    = OP_B0;
              state_next = ST_LOAD;
            end
          end else begin
            op_next    = next_op(op);
            state_next = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        stat.res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign mix_c = (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;
  assign x_sel = ch ? x_r : x_l;
  assign bx    = {x_sel[SAMPLE_BITS-1], x_sel};
  assign bw    = {wet[SAMPLE_BITS-1], wet};
  // The blend is formed as x * 2^16 + m * (wet - x), which equals the two-product form.
  assign bd    = bw - bx;

  always_comb begin
    unique case (op)
      OP_B0: begin
        mul_a = coef_b0;
        mul_b = bx;
      end
      OP_B1: begin
        mul_a = coef_b1;
        mul_b = bx;
      end
      OP_A1: begin
        mul_a = coef_a1;
        mul_b = bw;
      end
      OP_B2: begin
        mul_a = coef_b2;
        mul_b = bx;
      end
      OP_A2: begin
        mul_a = coef_a2;
        mul_b = bw;
      end
      OP_MIX: begin
        mul_a = {{(COEF_BITS-MIX_BITS){1'b0}}, mix_c};
        mul_b = bd;
      end
      default: begin
        mul_a = coef_b0;
        mul_b = bx;
      end
    endcase
  end

  sblm_serial_mult #(
    .A_BITS (COEF_BITS),
    .B_BITS (B_BITS)
  ) u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mstat),
    .prod  (prod)
  );

  assign p_ext = {{(W-PW){prod[PW-1]}}, prod};
  assign rnd   = (p_ext + HALF_F) >>> COEF_FRAC_BITS;
  assign x_e   = {{(W-SAMPLE_BITS){x_sel[SAMPLE_BITS-1]}}, x_sel};
  assign d1e   = {{(W-STATE_BITS){d1[ch][STATE_BITS-1]}}, d1[ch]};
  assign d2e   = {{(W-STATE_BITS){d2[ch][STATE_BITS-1]}}, d2[ch]};

  assign wet_sum = rnd + d1e;
  assign wet_sat = (wet_sum > S_MAX) ? S_MAX : ((wet_sum < S_MIN) ? S_MIN : wet_sum);
  assign tap1    = rnd + d2e;
  assign dnew    = acc - rnd;
  assign dnew_sat = (dnew > ST_MAX) ? ST_MAX : ((dnew < ST_MIN) ? ST_MIN : dnew);
  assign mix_sum = (p_ext + (x_e <<< MIX_FRAC_BITS) + HALF_M) >>> MIX_FRAC_BITS;
  assign mix_sat = (mix_sum > S_MAX) ? S_MAX : ((mix_sum < S_MIN) ? S_MIN : mix_sum);

  // Delay words: cleared by reset and by the clear command.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1[0] <= '0;
      d1[1] <= '0;
      d2[0] <= '0;
      d2[1] <= '0;
    end else if ((state == ST_IDLE) && start && cmd) begin
      d1[0] <= '0;
      d1[1] <= '0;
      d2[0] <= '0;
      d2[1] <= '0;
    end else if ((state == ST_WAIT) && mstat.done) begin
      if (op == OP_A1) begin
        d1[ch] <= dnew_sat[STATE_BITS-1:0];
      end
      if (op == OP_A2) begin
        d2[ch] <= dnew_sat[STATE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      x_l <= left_in;
      x_r <= right_in;
    end
    if ((state == ST_WAIT) && mstat.done) begin
      unique case (op)
        OP_B0:   wet <= wet_sat[SAMPLE_BITS-1:0];
        OP_B1:   acc <= tap1;
        OP_B2:   acc <= rnd;
        OP_MIX: begin
          if (ch) begin
            right_out <= mix_sat[SAMPLE_BITS-1:0];
          end else begin
            left_out <= mix_sat[SAMPLE_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/stereo_biquad_lowpass_mix_unit.sv @@
// Top level of the stereo biquad low-pass mix unit: configuration registers,
// stream ports and output register. Depends on sblm_pkg, sblm_core and the macro header.
`default_nettype none

`include "stereo_biquad_lowpass_mix_unit_macros.svh"

// Each transfer on the slave side carries one stereo pair and a command in tuser.
// A clear command zeroes all four delay words and yields no result.
// A filter command runs both channels through their own transposed direct form II
// section with the five shared coefficients and blends each with its dry input.
// All twelve products of an item (six per channel) go through one bit-serial
// multiplier that takes one multiplier bit per cycle; a filter item holds off new
// items until its result is taken. The result sits in an output register, so the
// next item is accepted while it waits on the master side. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module stereo_biquad_lowpass_mix_unit import sblm_pkg::*; #(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int STATE_BITS     = DEF_STATE_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]                  cfg_index,
  input  logic [COEF_BITS-1:0]                       cfg_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // Fields from bit 0 up: left_in, right_in, zero fill to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
  // Fields from bit 0 up: cmd.
  input  logic                                       s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // Fields from bit 0 up: left_out, right_out, zero fill to whole bytes.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_tdata
);

  localparam int DATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

  logic signed [COEF_BITS-1:0] coef_b0;
  logic signed [COEF_BITS-1:0] coef_b1;
  logic signed [COEF_BITS-1:0] coef_b2;
  logic signed [COEF_BITS-1:0] coef_a1;
  logic signed [COEF_BITS-1:0] coef_a2;
  logic        [MIX_BITS-1:0]  wet_mix;

  core_stat_t                    core_stat;
  logic                          core_start;
  logic                          res_take;
  logic signed [SAMPLE_BITS-1:0] core_left;
  logic signed [SAMPLE_BITS-1:0] core_right;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
      wet_mix <= MIX_ONE;
    end else if (cfg_we) begin
      // Indexes past the register list are ignored.
      case (cfg_index)
        REG_COEF_B0: coef_b0 <= cfg_data;
        REG_COEF_B1: coef_b1 <= cfg_data;
        REG_COEF_B2: coef_b2 <= cfg_data;
        REG_COEF_A1: coef_a1 <= cfg_data;
        REG_COEF_A2: coef_a2 <= cfg_data;
        REG_WET_MIX: wet_mix <= cfg_data[MIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready   = !core_stat.busy;
  assign core_start = s_tvalid && s_tready;
  assign res_take   = core_stat.res_valid && (!out_valid || m_tready);

  sblm_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_BITS     (STATE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (core_start),
    .cmd       (s_tuser),
    .left_in   (s_tdata[SAMPLE_BITS-1:0]),
    .right_in  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .coef_b0   (coef_b0),
    .coef_b1   (coef_b1),
    .coef_b2   (coef_b2),
    .coef_a1   (coef_a1),
    .coef_a2   (coef_a2),
    .wet_mix   (wet_mix),
    .res_take  (res_take),
    .stat      (core_stat),
    .left_out  (core_left),
    .right_out (core_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_left  <= core_left;
      out_right <= core_right;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = DATA_BITS'({out_right, out_left});

  `SBLM_ASSERT_NEXT(a_clear_frees_core, clk, rst, (s_tvalid && s_tready && s_tuser), s_tready)
  `SBLM_ASSERT_NEXT(a_filter_holds_core, clk, rst, (s_tvalid && s_tready && !s_tuser), !s_tready)
  `SBLM_ASSERT_NEXT(a_result_lands, clk, rst, res_take, out_valid)
  `SBLM_ASSERT_IMP(a_idle_has_no_result, clk, rst, s_tready, !core_stat.res_valid)

endmodule

`default_nettype wire

@@ tb/sv/stereo_biquad_lowpass_mix_unit_checker.sv @@
// Checker for the stereo biquad low-pass mix unit: watches the register writes and both
// stream channels, predicts each stereo output pair and compares it field by field.
// Depends on sblm_pkg for widths, register codes and the unity mix constant.
`timescale 1ns / 100ps

module stereo_biquad_lowpass_mix_unit_checker import sblm_pkg::*; (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]                  cfg_index,
  input  logic [COEF_BITS-1:0]                       cfg_data,
  input  logic                                       s_tvalid,
  input  logic                                       s_tready,
  // Fields from bit 0 up: left_in, right_in, zero fill to whole bytes.
  input  logic [((2*DEF_SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  // Fields from bit 0 up: cmd.
  input  logic                                       s_tuser,
  input  logic                                       m_tvalid,
  input  logic                                       m_tready,
  // Fields from bit 0 up: left_out, right_out, zero fill to whole bytes.
  input  logic [((2*DEF_SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
  output int                                         failures,
  output int                                         pending
);

  localparam int SW = DEF_SAMPLE_BITS;
  localparam int FRAC = DEF_COEF_FRAC_BITS;
  localparam int STW = DEF_STATE_BITS;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic [SW-1:0] right;
    logic [SW-1:0] left;
  } stereo_pair_t;

  stereo_pair_t pairs_due[$];

  longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [MIX_BITS-1:0] mix_reg;
  // Index 0 is the left channel, 1 the right one.
  longint delay_one[2];
  longint delay_two[2];
  int fail_total = 0;

  function automatic longint round_shift(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One transposed direct form II step plus the dry/wet blend; updates the delays of ch.
  function automatic logic [SW-1:0] filter_channel(input int ch, input logic [SW-1:0] sample);
    longint x, wet, n1, n2, m, blend;
    x = longint'($signed(sample));
    m = (mix_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_reg);
    wet = clamp(round_shift(coef_b0 * x, FRAC) + delay_one[ch], SW);
    n1 = round_shift(coef_b1 * x, FRAC) - round_shift(coef_a1 * wet, FRAC) + delay_two[ch];
    n2 = round_shift(coef_b2 * x, FRAC) - round_shift(coef_a2 * wet, FRAC);
    delay_one[ch] = clamp(n1, STW);
    delay_two[ch] = clamp(n2, STW);
    blend = clamp(round_shift((longint'(MIX_ONE) - m) * x + m * wet, MIX_FRAC_BITS), SW);
    return blend[SW-1:0];
  endfunction

  task automatic check_field(input string field, input logic [SW-1:0] want,
                             input logic [SW-1:0] got);
    if (got !== want) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    stereo_pair_t want;
    stereo_pair_t got;
    if (rst) begin
      coef_b0 = longint'(1) <<< FRAC;
      coef_b1 = 0;
      coef_b2 = 0;
      coef_a1 = 0;
      coef_a2 = 0;
      mix_reg = MIX_ONE;
      for (int ch = 0; ch < 2; ch++) begin
        delay_one[ch] = 0;
        delay_two[ch] = 0;
      end
      pairs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_B0: coef_b0 = longint'($signed(cfg_data));
          REG_COEF_B1: coef_b1 = longint'($signed(cfg_data));
          REG_COEF_B2: coef_b2 = longint'($signed(cfg_data));
          REG_COEF_A1: coef_a1 = longint'($signed(cfg_data));
          REG_COEF_A2: coef_a2 = longint'($signed(cfg_data));
          REG_WET_MIX: mix_reg = cfg_data[MIX_BITS-1:0];
          default: ;
        endcase
      end
      // Results leave before new items are counted, so a same-edge pair cannot alias.
      if (m_tvalid && m_tready) begin
        got = m_tdata[2*SW-1:0];
        if (pairs_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected output transfer %h", $time, got);
        end else begin
          want = pairs_due.pop_front();
          check_field("left_out", want.left, got.left);
          check_field("right_out", want.right, got.right);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_CLEAR) begin
          for (int ch = 0; ch < 2; ch++) begin
            delay_one[ch] = 0;
            delay_two[ch] = 0;
          end
        end else begin
          want.left = filter_channel(0, s_tdata[SW-1:0]);
          want.right = filter_channel(1, s_tdata[2*SW-1:SW]);
          pairs_due.push_back(want);
        end
      end
    end
    failures <= fail_total;
    pending <= pairs_due.size();
  end

endmodule

@@ tb/sv/stereo_biquad_lowpass_mix_unit_tb.sv @@
// Testbench top for the stereo biquad low-pass mix unit: clock, reset, register
// programming, stereo stimulus and output back-pressure. Needs sblm_pkg, the block
// and stereo_biquad_lowpass_mix_unit_checker, which predicts and compares.
`timescale 1ns / 100ps

module stereo_biquad_lowpass_mix_unit_tb;
  import sblm_pkg::*;

  localparam int SW = DEF_SAMPLE_BITS;
  localparam int DATA_W = ((2*SW+7)/8)*8;
  localparam int ITEM_CYCLES = 12 * (SW + 3) + 1;
  localparam int SETTLE_CYCLES = ITEM_CYCLES + 24;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS = 72;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic [SW-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SW-1:0] SAMPLE_MIN = 24'h800000;
  localparam logic [COEF_BITS-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_BITS-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [COEF_BITS-1:0] MIX_FULL = 32'h0001_0000;
  localparam logic [COEF_BITS-1:0] MIX_OVER = 32'h0001_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_COEF_B0;
  logic [COEF_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic s_tuser = CMD_FILTER;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;

  int failures;
  int pending;
  int cycle_count = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  always #1 clk = ~clk;

  stereo_biquad_lowpass_mix_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  stereo_biquad_lowpass_mix_unit_checker pair_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL stereo_biquad_lowpass_mix_unit");
      $finish;
    end
  end

  // Output side: random stalls before each transfer, or none while recv_steady is set.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = recv_steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_pair(input logic cmd, input logic [SW-1:0] left,
                           input logic [SW-1:0] right);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{(DATA_W-2*SW){1'b0}}, right, left};
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every expected pair has arrived and the core has surely gone idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [COEF_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Writes all six registers, plus junk to the two unused indexes, which must be ignored.
  task automatic set_regs(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                          input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                          input logic [COEF_BITS-1:0] a2, input logic [COEF_BITS-1:0] mix);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_SPARE_HI, $urandom);
    write_reg(REG_WET_MIX, mix);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SW-1:0] draw_sample();
    logic [SW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = SW'($urandom_range(0, 511) - 256);
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_phase();
    int b0, b1, b2, a1, a2, a2_mag, a1_mag;
    logic [COEF_BITS-1:0] mix;
    logic cmd;
    case ($urandom_range(0, 3))
      0: begin
        // Anything goes; mostly unstable, so saturation paths get heavy use.
        b0 = $urandom; b1 = $urandom; b2 = $urandom; a1 = $urandom; a2 = $urandom;
      end
      1: begin
        // Stable low-pass shape: b1 = 2*b0 = 2*b2, poles inside the unit circle.
        a2_mag = $urandom_range(0, 240_000_000);
        a1_mag = $urandom_range(0, 268_435_456 + a2_mag - 20_000_000);
        a2 = a2_mag;
        a1 = $urandom_range(0, 1) ? a1_mag : -a1_mag;
        b0 = $urandom_range(0, 1 << 26);
        b1 = 2 * b0;
        b2 = b0;
      end
      2: begin
        b0 = $urandom_range(0, 1 << 30) - (1 << 29);
        b1 = $urandom_range(0, 1 << 30) - (1 << 29);
        b2 = $urandom_range(0, 1 << 30) - (1 << 29);
        a1 = $urandom_range(0, 1 << 30) - (1 << 29);
        a2 = $urandom_range(0, 1 << 30) - (1 << 29);
      end
      default: begin
        b0 = $urandom_range(0, 1 << 31) - (1 << 30);
        b1 = $urandom_range(0, 1 << 20) - (1 << 19);
        b2 = $urandom_range(0, 1 << 20) - (1 << 19);
        a1 = $urandom_range(0, 1 << 20) - (1 << 19);
        a2 = $urandom_range(0, 1 << 20) - (1 << 19);
      end
    endcase
    case ($urandom_range(0, 4))
      0: mix = '0;
      1: mix = MIX_FULL;
      2: mix = $urandom_range(0, 65536);
      3: mix = $urandom;
      default: mix = $urandom_range(65536, 131071);
    endcase
    settle();
    set_regs(b0, b1, b2, a1, a2, mix);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 15) == 0) send_steady = ~send_steady;
      if ($urandom_range(0, 15) == 0) recv_steady = ~recv_steady;
      cmd = ($urandom_range(0, 19) == 0) ? CMD_CLEAR : CMD_FILTER;
      send_pair(cmd, draw_sample(), draw_sample());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients: unity gain, fully wet, so samples pass straight through.
    send_pair(CMD_FILTER, SAMPLE_MAX, SAMPLE_MIN);
    send_pair(CMD_FILTER, SAMPLE_MIN, SAMPLE_MAX);
    send_pair(CMD_FILTER, '0, '0);
    send_pair(CMD_FILTER, '1, 24'h000001);
    send_pair(CMD_CLEAR, '0, '0);
    send_pair(CMD_FILTER, 24'h000001, '1);

    // Extreme gains with the mix above one: the wet value saturates before feedback.
    settle();
    set_regs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, MIX_OVER);
    send_pair(CMD_FILTER, SAMPLE_MAX, SAMPLE_MIN);
    send_pair(CMD_FILTER, SAMPLE_MIN, SAMPLE_MAX);
    send_pair(CMD_FILTER, SAMPLE_MAX, SAMPLE_MAX);
    send_pair(CMD_CLEAR, SAMPLE_MAX, SAMPLE_MIN);
    send_pair(CMD_FILTER, SAMPLE_MIN, SAMPLE_MIN);

    // Opposite extremes, fully dry.
    settle();
    set_regs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, '0);
    send_pair(CMD_FILTER, SAMPLE_MAX, SAMPLE_MIN);
    send_pair(CMD_FILTER, SAMPLE_MIN, SAMPLE_MAX);
    send_pair(CMD_FILTER, 24'h000001, '1);

    // Moderate filter at half mix, with a clear in the middle of a run.
    settle();
    set_regs(32'h0800_0000, 32'h1000_0000, 32'h0400_0000, 32'hF000_0000, 32'h0200_0000,
             32'h0000_8000);
    send_pair(CMD_FILTER, SAMPLE_MAX, SAMPLE_MIN);
    send_pair(CMD_FILTER, '1, 24'h000001);
    send_pair(CMD_CLEAR, '0, '0);
    send_pair(CMD_FILTER, SAMPLE_MIN, SAMPLE_MAX);
    send_pair(CMD_FILTER, '0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++)
      random_phase();

    settle();
    if (failures == 0 && pending == 0) begin
      $display("PASS stereo_biquad_lowpass_mix_unit");
    end else begin
      $display("FAIL stereo_biquad_lowpass_mix_unit");
    end
    $finish;
  end

endmodule
